// ===== src/icdg_pkg.sv =====
package icdg_pkg;

    // default image limits
    localparam int unsigned DEF_MAX_ROWS = 1024;
    localparam int unsigned DEF_MAX_COLS = 1024;

    // field widths on the stream ports
    localparam int PIX_W   = 8;
    localparam int GRAD_W  = 9;
    localparam int POS_W   = 10;
    localparam int SIZE_W  = 11;
    localparam int OUT_W   = 40;
    localparam int CFG_IDX_W = 2;

    // size register reset values
    localparam logic [SIZE_W-1:0] RESET_ROWS = 11'd480;
    localparam logic [SIZE_W-1:0] RESET_COLS = 11'd640;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COLS = 2'd1;

    // one inner gradient and the border positions that copy it
    typedef struct packed {
        logic signed [GRAD_W-1:0] grad_x;
        logic signed [GRAD_W-1:0] grad_y;
        logic [POS_W-1:0]         row;
        logic [POS_W-1:0]         col;
        logic [POS_W-1:0]         row_alt;   // last row, used by the bottom border copy
        logic [POS_W-1:0]         col_alt;   // last column, used by the right border copy
        logic [2:0]               row_mask;  // {last row, row 0, own row}
        logic [2:0]               col_mask;  // {last column, column 0, own column}
    } t_job;

    // size clamped to 3..maxv
    function automatic int unsigned clamp_size(logic [SIZE_W-1:0] v, int unsigned maxv);
        int unsigned res;
        res = 32'(v);
        if (res < 3) begin
            res = 3;
        end else if (res > maxv) begin
            res = maxv;
        end
        return res;
    endfunction

endpackage

// ===== src/icdg_emit.sv =====
module icdg_emit
    import icdg_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_job_valid,
    input  t_job            i_job,
    output logic            o_job_ready,
    output logic            o_m_axis_tvalid,
    input  logic            i_m_axis_tready,
    output logic [OUT_W-1:0] o_m_axis_tdata,  // grad_x, grad_y, out_row, out_col, zero pad
    output logic            o_m_axis_tlast    // last_in_run
);

    logic             r_job_valid;
    t_job             r_job;
    logic [2:0]       r_row_left;
    logic [2:0]       r_col_left;
    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_data;
    logic             r_out_last;

    logic             adv;
    logic             take;
    logic [2:0]       row_low;
    logic [2:0]       col_low;
    logic             row_more;
    logic             col_more;
    logic             item_last;
    logic [POS_W-1:0] sel_row;
    logic [POS_W-1:0] sel_col;

    // walk order: columns outer, rows inner, lowest slot first
    always_comb begin
        adv       = !r_out_valid || i_m_axis_tready;
        take      = r_job_valid && adv;
        row_low   = r_row_left & 3'(~r_row_left + 3'd1);
        col_low   = r_col_left & 3'(~r_col_left + 3'd1);
        row_more  = (r_row_left & 3'(r_row_left - 3'd1)) != 3'd0;
        col_more  = (r_col_left & 3'(r_col_left - 3'd1)) != 3'd0;
        item_last = !row_more && !col_more;
        o_job_ready = !r_job_valid || (adv && item_last);
    end

    // position of the current copy
    always_comb begin
        priority if (row_low[0]) begin
            sel_row = r_job.row;
        end else if (row_low[1]) begin
            sel_row = '0;
        end else begin
            sel_row = r_job.row_alt;
        end
        priority if (col_low[0]) begin
            sel_col = r_job.col;
        end else if (col_low[1]) begin
            sel_col = '0;
        end else begin
            sel_col = r_job.col_alt;
        end
    end

    // job and output control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_row_left  <= '0;
            r_col_left  <= '0;
        end else begin
            if (adv) begin
                r_out_valid <= r_job_valid;
            end
            if (o_job_ready) begin
                r_job_valid <= i_job_valid;
                if (i_job_valid) begin
                    r_row_left <= i_job.row_mask;
                    r_col_left <= i_job.col_mask;
                end
            end else if (take) begin
                if (row_more) begin
                    r_row_left <= r_row_left & 3'(r_row_left - 3'd1);
                end else begin
                    r_row_left <= r_job.row_mask;
                    r_col_left <= r_col_left & 3'(r_col_left - 3'd1);
                end
            end
        end
    end

    // job payload and output word
    always_ff @(posedge i_clk) begin
        if (o_job_ready && i_job_valid) begin
            r_job <= i_job;
        end
        if (take) begin
            r_out_data <= {2'b00, sel_col, sel_row, r_job.grad_y, r_job.grad_x};
            r_out_last <= item_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

    // a live job always has a row and a column slot left
    a_row_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_job_valid |-> r_row_left != 3'd0)
        else $error("row walk ran empty");

    a_col_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_job_valid |-> r_col_left != 3'd0)
        else $error("column walk ran empty");

    // the row walk never visits a slot the job did not ask for
    a_row_subset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_job_valid |-> (r_row_left & ~r_job.row_mask) == 3'd0)
        else $error("row walk outside job mask");

    // own position always comes with the job
    a_base_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_job_valid |-> (r_job.row_mask[0] && r_job.col_mask[0]))
        else $error("job without own position");

endmodule

// ===== src/image_central_difference_gradient.sv =====
// channel   | direction | handshake                | payload
// s_axis    | in        | i_s_axis_tvalid/tready   | tdata[7:0] pixel, column-major
// m_axis    | out       | o_m_axis_tvalid/tready   | tdata gradients and position, tlast
// cfg       | in        | i_cfg_valid/o_cfg_ready  | index 0 rows, 1 cols, 11-bit data
//
// one pixel a cycle while the output drains and no border copy or size write
// holds the input; the column store is a single 16-bit wide memory with one
// write and one prefetch read per pixel; an inner pixel feeding border copies
// holds the input while its extra results are sent, up to eight at a corner
// synchronous active-low reset; column store contents are not cleared
// a size write restarts the image at row 0, column 0 and holds the input that cycle
module image_central_difference_gradient
    import icdg_pkg::*;
#(
    parameter int unsigned MAX_ROWS = DEF_MAX_ROWS,
    parameter int unsigned MAX_COLS = DEF_MAX_COLS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [PIX_W-1:0]     i_s_axis_tdata,   // pixel
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [OUT_W-1:0]     o_m_axis_tdata,   // grad_x, grad_y, out_row, out_col, pad
    output logic                 o_m_axis_tlast,   // last_in_run
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [SIZE_W-1:0]    i_cfg_data
);

    localparam int RW = $clog2(MAX_ROWS);
    localparam int CW = $clog2(MAX_COLS);
    localparam logic [RW-1:0] ROWS_LAST_RST = RW'(clamp_size(RESET_ROWS, MAX_ROWS) - 1);
    localparam logic [RW-1:0] ROWS_PEN_RST  = RW'(clamp_size(RESET_ROWS, MAX_ROWS) - 2);
    localparam logic [CW-1:0] COLS_LAST_RST = CW'(clamp_size(RESET_COLS, MAX_COLS) - 1);

    logic [RW-1:0]      r_row;
    logic [CW-1:0]      r_col;
    logic [RW-1:0]      r_rows_last;
    logic [RW-1:0]      r_rows_pen;
    logic [CW-1:0]      r_cols_last;

    // column store: entry r holds {newest column, column before}
    logic [2*PIX_W-1:0] r_mem [MAX_ROWS];
    logic [2*PIX_W-1:0] r_rd;     // entry of the next row
    logic [2*PIX_W-1:0] r_cur;    // entry of this row
    logic [PIX_W-1:0]   r_up;     // previous column, row above

    logic               s_acc;
    logic               emit;
    logic [RW-1:0]      rd_addr;
    t_job               job;
    logic               job_ready;

    assign o_cfg_ready     = 1'b1;
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = job_ready && !i_cfg_valid;

    // prefetch address: two rows ahead, wrapping into the next column
    always_comb begin
        priority if (r_row == r_rows_pen) begin
            rd_addr = '0;
        end else if (r_row == r_rows_last) begin
            rd_addr = RW'(1);
        end else begin
            rd_addr = RW'(r_row + RW'(2));
        end
    end

    // inner gradient of the pixel one column back
    always_comb begin
        emit = (r_col >= CW'(2)) && (r_row != '0) && (r_row <= r_rows_pen);
        job.grad_x   = GRAD_W'(signed'({1'b0, i_s_axis_tdata}) -
                               signed'({1'b0, r_cur[PIX_W-1:0]}));
        job.grad_y   = GRAD_W'(signed'({1'b0, r_rd[2*PIX_W-1:PIX_W]}) -
                               signed'({1'b0, r_up}));
        job.row      = POS_W'(r_row);
        job.col      = POS_W'(CW'(r_col - CW'(1)));
        job.row_alt  = POS_W'(r_rows_last);
        job.col_alt  = POS_W'(r_cols_last);
        job.row_mask = {r_row == r_rows_pen, r_row == RW'(1), 1'b1};
        job.col_mask = {r_col == r_cols_last, r_col == CW'(2), 1'b1};
    end

    // sizes and position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row       <= '0;
            r_col       <= '0;
            r_rows_last <= ROWS_LAST_RST;
            r_rows_pen  <= ROWS_PEN_RST;
            r_cols_last <= COLS_LAST_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_IMAGE_ROWS: begin
                    r_rows_last <= RW'(clamp_size(i_cfg_data, MAX_ROWS) - 1);
                    r_rows_pen  <= RW'(clamp_size(i_cfg_data, MAX_ROWS) - 2);
                    r_row       <= '0;
                    r_col       <= '0;
                end
                CFG_IMAGE_COLS: begin
                    r_cols_last <= CW'(clamp_size(i_cfg_data, MAX_COLS) - 1);
                    r_row       <= '0;
                    r_col       <= '0;
                end
                default: begin
                end
            endcase
        end else if (s_acc) begin
            if (r_row == r_rows_last) begin
                r_row <= '0;
                if (r_col == r_cols_last) begin
                    r_col <= '0;
                end else begin
                    r_col <= CW'(r_col + CW'(1));
                end
            end else begin
                r_row <= RW'(r_row + RW'(1));
            end
        end
    end

    // column store write, prefetch read and row window
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_mem[r_row] <= {i_s_axis_tdata, r_cur[2*PIX_W-1:PIX_W]};
            r_rd         <= r_mem[rd_addr];
            r_cur        <= r_rd;
            r_up         <= r_cur[2*PIX_W-1:PIX_W];
        end
    end

    icdg_emit u_emit (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_job_valid     (s_acc && emit),
        .i_job           (job),
        .o_job_ready     (job_ready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule
